### hdl/lzsd_pkg.sv
// Shared types and constants of the LZSS stream decompressor.
`default_nettype none

package lzsd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LIMIT_W    = 24;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned BITS_W     = 4;   // holds 0..8 bits left in a byte
  localparam int unsigned MIN_MATCH  = 2;

  localparam logic [BYTE_W-1:0]  RING_FILL   = 8'h20;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hFF_FFFF;
  localparam logic [BITS_W-1:0]  BYTE_BITS   = 4'd8;

  // register index, taken from the word address
  localparam logic REG_OUTPUT_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_END     = 2'd1,
    ST_LIMIT   = 2'd2,
    ST_EXHAUST = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_FLAG    = 2'd0,
    PH_LITERAL = 2'd1,
    PH_INDEX   = 2'd2,
    PH_LENGTH  = 2'd3
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BIT  = 5'b00010,
    S_CRD  = 5'b00100,
    S_CDAT = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    status_e           status;
  } result_t;

endpackage

`default_nettype wire

### hdl/lzss_stream_decompressor_top.sv
// LZSS stream decompressor: one compressed byte in, data bytes and status results out.
//
// A byte is taken while the decoder is idle and then decoded one bit per cycle while there is
// room for a result; a back-reference that completes in it first primes the history read and
// then copies its bytes (up to 2^LENGTH_BITS+1), and an input-exhausted status is given from a
// state of its own. A byte that arrives after the stream is done is dropped in the cycle it
// is taken. The history ring is a single 2^INDEX_BITS x 8 RAM; copy bytes stream out of it
// at one per cycle while there is room for the result, bypassing the write of the previous
// byte when a copy overlaps its own output. No clearing pass is needed after reset or a
// restart: a fill count marks which entries have been written, and unwritten entries read
// as a space (0x20). Results wait in a staging register and an output register, so the next
// byte is taken while a result is pending; the decoder holds when both are full.
`default_nettype none

module lzss_stream_decompressor_top #(
  parameter int unsigned INDEX_BITS  = 10,
  parameter int unsigned LENGTH_BITS = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // compressed input
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [lzsd_pkg::BYTE_W-1:0]        s_axis_tdata_i,  // [7:0] in_byte
  input  wire logic                               s_axis_tuser_i,  // [0] start_stream
  input  wire logic                               s_axis_tlast_i,  // final_byte
  // decompressed output
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  output logic      [lzsd_pkg::BYTE_W-1:0]        m_axis_tdata_o,  // [7:0] out_byte
  output logic      [1:0]                         m_axis_tuser_o,  // [1:0] status
  output logic                                    m_axis_tlast_o,  // last_of_run
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lzsd_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [lzsd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [lzsd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                    pready
);

  import lzsd_pkg::*;

  localparam int unsigned RING_DEPTH = 1 << INDEX_BITS;
  localparam int unsigned FILL_W     = INDEX_BITS + 1;
  localparam int unsigned TOK_W      = INDEX_BITS + LENGTH_BITS;
  localparam int unsigned CNT_W      = $clog2(INDEX_BITS + 1);
  localparam int unsigned LEN_W      = LENGTH_BITS + 1;

  // control state
  state_e                  state_q, state_d;
  phase_e                  phase_q, phase_d;
  logic [TOK_W-1:0]        tok_q, tok_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [BITS_W-1:0]       left_q, left_d;
  logic                    final_q, final_d;
  logic                    done_q, done_d;
  logic [INDEX_BITS-1:0]   wp_q, wp_d;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic [LIMIT_W-1:0]      be_q, be_d;
  logic [LIMIT_W-1:0]      limit_q, limit_d;
  logic [LEN_W-1:0]        cp_left_q, cp_left_d;
  logic                    rvalid_q, rvalid_d;
  logic                    fwd_q, fwd_d;
  logic                    stg_valid_q, stg_valid_d;
  logic                    m_valid_q, m_valid_d;

  // payload
  logic [BYTE_W-1:0]       sh_q, sh_d;
  logic [INDEX_BITS-1:0]   cp_addr_q, cp_addr_d;
  logic [BYTE_W-1:0]       fwd_data_q, fwd_data_d;
  result_t                 stg_q, stg_d;
  result_t                 m_res_q, m_res_d;
  logic                    m_last_q, m_last_d;

  // ring port
  logic                    ram_we;
  logic                    ram_re;
  logic [INDEX_BITS-1:0]   ram_raddr;
  logic [BYTE_W-1:0]       ram_rdata;

  logic                    can_push;
  logic                    res_ok;
  logic                    accept;
  logic                    flush;
  logic                    new_valid;
  result_t                 new_res;
  logic                    emit_req;
  logic [BYTE_W-1:0]       emit_val;
  logic                    limit_hit;
  logic                    bit_b;
  logic [CNT_W-1:0]        cnt_inc;
  logic [TOK_W-1:0]        tok_shift;
  logic [BYTE_W-1:0]       copy_byte;
  logic [INDEX_BITS-1:0]   cp_next;
  state_e                  after_bits;
  logic                    cfg_wr;
  logic                    cfg_sel;

  lzsd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (emit_val),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // configuration port
  assign pready  = 1'b1;
  assign cfg_sel = (paddr == PADDR_W'(0)) ? 1'b1 : 1'b0;
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign limit_d = cfg_wr ? pwdata[LIMIT_W-1:0] : limit_q;

  always_comb begin
    prdata = '0;
    if (cfg_sel && paddr[2] == REG_OUTPUT_LIMIT) begin
      prdata = APB_DATA_W'(limit_q);
    end
  end

  // handshakes
  assign can_push        = !m_valid_q || m_axis_tready_i;
  assign res_ok          = !stg_valid_q || can_push;
  assign s_axis_tready_o = (state_q == S_IDLE) && res_ok;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign flush           = (state_q == S_IDLE) && stg_valid_q && can_push;

  // bit decode helpers
  assign bit_b     = sh_q[BYTE_W-1];
  assign cnt_inc   = cnt_q + 1'b1;
  assign tok_shift = {tok_q[TOK_W-2:0], bit_b};
  assign limit_hit = (be_q >= limit_q);
  assign copy_byte = fwd_q ? fwd_data_q : (rvalid_q ? ram_rdata : RING_FILL);
  assign cp_next   = cp_addr_q + 1'b1;
  assign after_bits = (left_q == '0) ? (final_q ? S_FIN : S_IDLE) : S_BIT;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    tok_d      = tok_q;
    cnt_d      = cnt_q;
    left_d     = left_q;
    final_d    = final_q;
    done_d     = done_q;
    wp_d       = wp_q;
    fill_d     = fill_q;
    be_d       = be_q;
    cp_left_d  = cp_left_q;
    cp_addr_d  = cp_addr_q;
    rvalid_d   = rvalid_q;
    fwd_d      = fwd_q;
    fwd_data_d = fwd_data_q;
    sh_d       = sh_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = cp_addr_q;
    new_valid  = 1'b0;
    new_res    = '{data: '0, status: ST_DATA};
    emit_req   = 1'b0;
    emit_val   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          sh_d    = s_axis_tdata_i;
          left_d  = BYTE_BITS;
          final_d = s_axis_tlast_i;
          if (s_axis_tuser_i) begin
            phase_d = PH_FLAG;
            tok_d   = '0;
            cnt_d   = '0;
            wp_d    = '0;
            fill_d  = '0;
            be_d    = '0;
            done_d  = 1'b0;
            state_d = S_BIT;
          end else if (!done_q) begin
            state_d = S_BIT;
          end
        end
      end

      S_BIT: begin
        // each bit waits for room for a result, whether or not it yields one
        if (res_ok) begin
          sh_d    = {sh_q[BYTE_W-2:0], 1'b0};
          left_d  = left_q - 1'b1;
          state_d = (left_q == BITS_W'(1)) ? (final_q ? S_FIN : S_IDLE) : S_BIT;
          case (phase_q)
            PH_FLAG: begin
              tok_d   = '0;
              cnt_d   = '0;
              phase_d = bit_b ? PH_LITERAL : PH_INDEX;
            end
            PH_LITERAL: begin
              tok_d = TOK_W'(tok_shift[BYTE_W-1:0]);
              cnt_d = cnt_inc;
              if (cnt_inc >= CNT_W'(BYTE_W)) begin
                phase_d  = PH_FLAG;
                tok_d    = '0;
                cnt_d    = '0;
                emit_req = 1'b1;
                emit_val = tok_shift[BYTE_W-1:0];
              end
            end
            PH_INDEX: begin
              tok_d = TOK_W'(tok_shift[INDEX_BITS-1:0]);
              cnt_d = cnt_inc;
              if (cnt_inc >= CNT_W'(INDEX_BITS)) begin
                if (tok_shift[INDEX_BITS-1:0] == '0) begin
                  // end marker: rest of the byte is dropped
                  new_valid      = 1'b1;
                  new_res.status = ST_END;
                  done_d         = 1'b1;
                  state_d        = S_IDLE;
                end else begin
                  phase_d = PH_LENGTH;
                  cnt_d   = '0;
                end
              end
            end
            PH_LENGTH: begin
              tok_d = tok_shift;
              cnt_d = cnt_inc;
              if (cnt_inc >= CNT_W'(LENGTH_BITS)) begin
                phase_d   = PH_FLAG;
                tok_d     = '0;
                cnt_d     = '0;
                cp_addr_d = tok_shift[TOK_W-1:LENGTH_BITS] - 1'b1;
                cp_left_d = LEN_W'(tok_shift[LENGTH_BITS-1:0]) + LEN_W'(MIN_MATCH);
                state_d   = S_CRD;
              end
            end
            default: begin
              phase_d = PH_FLAG;
            end
          endcase
        end
      end

      S_CRD: begin
        ram_re    = 1'b1;
        ram_raddr = cp_addr_q;
        rvalid_d  = ({1'b0, cp_addr_q} < fill_q);
        fwd_d     = 1'b0;
        state_d   = S_CDAT;
      end

      S_CDAT: begin
        if (!res_ok) begin
          // no room: read the same entry again
          ram_re    = 1'b1;
          ram_raddr = cp_addr_q;
          rvalid_d  = ({1'b0, cp_addr_q} < fill_q);
          fwd_d     = 1'b0;
        end else begin
          emit_req  = 1'b1;
          emit_val  = copy_byte;
          cp_addr_d = cp_next;
          cp_left_d = cp_left_q - 1'b1;
          if (cp_left_q == LEN_W'(1)) begin
            state_d = after_bits;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = cp_next;
            rvalid_d   = ({1'b0, cp_next} < fill_q);
            // next source entry is the one written this cycle
            fwd_d      = (cp_next == wp_q);
            fwd_data_d = copy_byte;
          end
        end
      end

      S_FIN: begin
        if (res_ok) begin
          new_valid      = 1'b1;
          new_res.status = ST_EXHAUST;
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit_req) begin
      new_valid = 1'b1;
      if (limit_hit) begin
        new_res.status = ST_LIMIT;
        done_d         = 1'b1;
        state_d        = S_IDLE;
      end else begin
        new_res.data = emit_val;
        ram_we       = 1'b1;
        wp_d         = wp_q + 1'b1;
        be_d         = be_q + 1'b1;
        if (fill_q != FILL_W'(RING_DEPTH)) begin
          fill_d = fill_q + 1'b1;
        end
      end
    end
  end

  // result staging: the held result goes out once it is known whether it closes the run
  always_comb begin
    stg_valid_d = stg_valid_q;
    stg_d       = stg_q;
    m_res_d     = m_res_q;
    m_last_d    = m_last_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    if (new_valid) begin
      stg_valid_d = 1'b1;
      stg_d       = new_res;
      if (stg_valid_q) begin
        m_valid_d = 1'b1;
        m_res_d   = stg_q;
        m_last_d  = 1'b0;
      end
    end else if (flush) begin
      stg_valid_d = 1'b0;
      m_valid_d   = 1'b1;
      m_res_d     = stg_q;
      m_last_d    = 1'b1;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_res_q.data;
  assign m_axis_tuser_o  = m_res_q.status;
  assign m_axis_tlast_o  = m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FLAG;
      tok_q       <= '0;
      cnt_q       <= '0;
      left_q      <= '0;
      final_q     <= 1'b0;
      done_q      <= 1'b0;
      wp_q        <= '0;
      fill_q      <= '0;
      be_q        <= '0;
      limit_q     <= LIMIT_RESET;
      cp_left_q   <= '0;
      rvalid_q    <= 1'b0;
      fwd_q       <= 1'b0;
      stg_valid_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      tok_q       <= tok_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      final_q     <= final_d;
      done_q      <= done_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      be_q        <= be_d;
      limit_q     <= limit_d;
      cp_left_q   <= cp_left_d;
      rvalid_q    <= rvalid_d;
      fwd_q       <= fwd_d;
      stg_valid_q <= stg_valid_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q       <= sh_d;
    cp_addr_q  <= cp_addr_d;
    fwd_data_q <= fwd_data_d;
    stg_q      <= stg_d;
    m_res_q    <= m_res_d;
    m_last_q   <= m_last_d;
  end

endmodule

`default_nettype wire

### hdl/lzsd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lzsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read during write to the same entry returns the old data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
